// ----- design/plcsm_pkg.sv -----
package plcsm_pkg;

  // operation codes of an input transaction
  localparam logic [2:0] OP_READ       = 3'd0;
  localparam logic [2:0] OP_WRITE_BIT  = 3'd1;
  localparam logic [2:0] OP_WRITE_WORD = 3'd2;
  localparam logic [2:0] OP_RX_BYTE    = 3'd3;
  localparam logic [2:0] OP_TICK       = 3'd4;

  // command kinds held while a command runs
  localparam logic [1:0] CMD_READ       = 2'd0;
  localparam logic [1:0] CMD_WRITE_BIT  = 2'd1;
  localparam logic [1:0] CMD_WRITE_WORD = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_WORD   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // status codes
  localparam logic [2:0] ST_BUSY    = 3'd0;
  localparam logic [2:0] ST_OK      = 3'd1;
  localparam logic [2:0] ST_CRC     = 3'd2;
  localparam logic [2:0] ST_TIMEOUT = 3'd3;
  localparam logic [2:0] ST_SIZE    = 3'd4;

  // configuration register indexes
  localparam logic CFG_READ_TIMEOUT  = 1'b0;
  localparam logic CFG_WRITE_TIMEOUT = 1'b1;

  // frame constants
  localparam logic [7:0]  HOST_ID    = 8'd191;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] TIMEOUT_RST = 16'd1000;

  // reflected crc-16 over one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- design/plcsm_in_if.sv -----
interface plcsm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [7:0]  station;
  logic [15:0] reg_address;
  logic [15:0] write_value;
  logic [7:0]  word_count;
  logic        is_analog;
  logic [15:0] target_base;
  logic [7:0]  rx_byte;

  modport source (output valid, operation, station, reg_address, write_value, word_count,
                  is_analog, target_base, rx_byte, input ready);
  modport sink (input valid, operation, station, reg_address, write_value, word_count,
                is_analog, target_base, rx_byte, output ready);
endinterface

// ----- design/plcsm_out_if.sv -----
interface plcsm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  tx_byte;
  logic [15:0] store_index;
  logic [15:0] store_value;
  logic [2:0]  status;
  logic        last;

  modport source (output valid, kind, tx_byte, store_index, store_value, status, last,
                  input ready);
  modport sink (input valid, kind, tx_byte, store_index, store_value, status, last,
                output ready);
endinterface

// ----- design/plcsm_rx_mem.sv -----
module plcsm_rx_mem #(
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [7:0]               rdata_a_o,
  output logic [7:0]               rdata_b_o
);

  logic [7:0] mem [DEPTH];

  // one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

// ----- design/plc_serial_master_transaction.sv -----
// Master side of a two-phase PLC serial exchange with CRC-16 framing.
// Input channel in_s carries one transaction per command, received line byte
// or timer tick; the output channel out_s carries transmit bytes, stored words
// and status results, with last set on the final result of each input that has any.
// The block handles one input at a time: in_s.ready is high only while the
// sequencer is idle. A start command emits its 9- or 10-byte request frame one
// byte per cycle while the output register is free. A received byte is first
// written to the buffer, then the frame is checked; a completed acknowledgement
// then emits the 7-byte poll frame at one byte per cycle, again while the output
// register is free. A completed read response emits one stored word after each
// registered buffer read. A tick updates the timer; a timeout emits a status.
// Received bytes sit in a single synchronous buffer of RX_BUFFER_BYTES bytes;
// the frame CRC is kept running as bytes arrive.
// Results leave through an output register; while it holds a result and
// out_s.ready is low, the emitting states hold. Reset returns to idle, both timeout
// registers to 1000 ticks; the buffer needs no clearing.
// Configuration writes (cfg_we_i, cfg_index_i, cfg_data_i) take effect at once.
module plc_serial_master_transaction #(
  parameter int RX_BUFFER_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  plcsm_in_if.sink    in_s,
  plcsm_out_if.source out_s
);
  import plcsm_pkg::*;

  localparam int AW = $clog2(RX_BUFFER_BYTES);
  localparam int CW = $clog2(RX_BUFFER_BYTES + 1);

  typedef enum logic [1:0] {PH_IDLE, PH_ACK, PH_RESP} phase_e;
  typedef enum logic [2:0] {S_IDLE, S_CHK, S_TX, S_ST, S_AREQ, S_ACH, S_WREQ, S_WOUT} state_e;

  state_e      state_q;
  phase_e      phase_q;
  logic [15:0] rd_to_q, wr_to_q;
  logic [1:0]  cmd_q;
  logic [7:0]  station_q, count_q;
  logic        analog_q;
  logic [15:0] target_q;
  logic [CW-1:0] rx_count_q;
  logic [15:0] tick_q;
  logic [9:0]  need_q;
  logic [15:0] crc_rx_q;
  logic [7:0]  byte_old_q, byte_new_q;
  logic [7:0]  frame_q [8];
  logic [3:0]  flen_q, fidx_q;
  logic [15:0] crc_tx_q;
  logic [2:0]  post_st_q;
  logic [AW-1:0] waddr_q;
  logic [15:0] widx_q;
  logic [7:0]  wleft_q;

  logic        out_valid_q;
  logic [1:0]  out_kind_q;
  logic [7:0]  out_tx_q;
  logic [15:0] out_idx_q, out_val_q;
  logic [2:0]  out_st_q;
  logic        out_last_q;

  logic          in_fire, out_free, out_load;
  logic [15:0]   lim, tick_inc;
  logic          crc_ok;
  logic [7:0]    words;
  logic [9:0]    need_calc;
  logic [7:0]    tx_cur;
  logic          mem_we, mem_re;
  logic [AW-1:0] rd_a, rd_b;
  logic [7:0]    rdata_a, rdata_b;

  // handshake and helpers
  assign in_s.ready = (state_q == S_IDLE);
  assign in_fire    = in_s.valid && in_s.ready;
  assign out_free   = !out_valid_q || out_s.ready;
  assign out_load   = out_free && (state_q == S_TX || state_q == S_ST || state_q == S_WOUT);
  assign lim        = (cmd_q == CMD_READ) ? rd_to_q : wr_to_q;
  assign tick_inc   = (tick_q == 16'hFFFF) ? tick_q : tick_q + 16'd1;
  assign crc_ok     = (crc_rx_q == {byte_new_q, byte_old_q});
  assign words      = analog_q ? 8'd2 : count_q;
  assign need_calc  = 10'd6 + {1'b0, words, 1'b0};

  always_comb begin
    if (fidx_q < flen_q) begin
      tx_cur = frame_q[fidx_q[2:0]];
    end else if (fidx_q == flen_q) begin
      tx_cur = crc_tx_q[7:0];
    end else begin
      tx_cur = crc_tx_q[15:8];
    end
  end

  // receive buffer
  assign mem_we = in_fire && (in_s.operation == OP_RX_BYTE) && (phase_q != PH_IDLE)
                  && (rx_count_q < CW'(RX_BUFFER_BYTES));
  assign mem_re = (state_q == S_AREQ) || (state_q == S_WREQ);
  assign rd_a   = (state_q == S_AREQ) ? AW'(6) : waddr_q;
  assign rd_b   = rd_a + AW'(1);

  plcsm_rx_mem #(.DEPTH(RX_BUFFER_BYTES)) u_rx_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (rx_count_q[AW-1:0]),
    .wdata_i   (in_s.rx_byte),
    .re_i      (mem_re),
    .raddr_a_i (rd_a),
    .raddr_b_i (rd_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // output channel
  assign out_s.valid       = out_valid_q;
  assign out_s.kind        = out_kind_q;
  assign out_s.tx_byte     = out_tx_q;
  assign out_s.store_index = out_idx_q;
  assign out_s.store_value = out_val_q;
  assign out_s.status      = out_st_q;
  assign out_s.last        = out_last_q;

  // sequencer, command state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_IDLE;
      rd_to_q     <= TIMEOUT_RST;
      wr_to_q     <= TIMEOUT_RST;
      cmd_q       <= CMD_READ;
      station_q   <= '0;
      count_q     <= '0;
      analog_q    <= 1'b0;
      target_q    <= '0;
      rx_count_q  <= '0;
      tick_q      <= '0;
      need_q      <= '0;
      crc_rx_q    <= CRC_INIT;
      byte_old_q  <= '0;
      byte_new_q  <= '0;
      for (int i = 0; i < 8; i++) begin
        frame_q[i] <= '0;
      end
      flen_q      <= '0;
      fidx_q      <= '0;
      crc_tx_q    <= CRC_INIT;
      post_st_q   <= ST_BUSY;
      waddr_q     <= '0;
      widx_q      <= '0;
      wleft_q     <= '0;
      out_valid_q <= 1'b0;
      out_kind_q  <= KIND_TX;
      out_tx_q    <= '0;
      out_idx_q   <= '0;
      out_val_q   <= '0;
      out_st_q    <= ST_BUSY;
      out_last_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_READ_TIMEOUT) begin
          rd_to_q <= cfg_data_i;
        end else begin
          wr_to_q <= cfg_data_i;
        end
      end

      // drained and nothing new to load
      if (out_s.ready && !out_load) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (in_s.operation == OP_READ || in_s.operation == OP_WRITE_BIT
                || in_s.operation == OP_WRITE_WORD) begin
              // start: build request frame
              cmd_q      <= in_s.operation[1:0];
              station_q  <= in_s.station;
              count_q    <= in_s.word_count;
              analog_q   <= in_s.is_analog;
              target_q   <= in_s.target_base;
              frame_q[0] <= in_s.station;
              frame_q[1] <= HOST_ID;
              frame_q[4] <= in_s.reg_address[7:0];
              frame_q[5] <= in_s.reg_address[15:8];
              frame_q[7] <= in_s.write_value[15:8];
              if (in_s.operation == OP_READ) begin
                frame_q[2] <= 8'd3;
                frame_q[3] <= 8'd3;
                frame_q[6] <= in_s.is_analog ? 8'd2 : in_s.word_count;
                flen_q     <= 4'd7;
              end else if (in_s.operation == OP_WRITE_BIT) begin
                frame_q[2] <= 8'd2;
                frame_q[3] <= 8'd3;
                frame_q[6] <= in_s.write_value[7:0];
                flen_q     <= 4'd7;
              end else begin
                frame_q[2] <= 8'd4;
                frame_q[3] <= 8'd4;
                frame_q[6] <= in_s.write_value[7:0];
                flen_q     <= 4'd8;
              end
              fidx_q     <= '0;
              crc_tx_q   <= CRC_INIT;
              post_st_q  <= ST_BUSY;
              phase_q    <= PH_ACK;
              rx_count_q <= '0;
              tick_q     <= '0;
              crc_rx_q   <= CRC_INIT;
              state_q    <= S_TX;
            end else if (in_s.operation == OP_RX_BYTE && phase_q != PH_IDLE) begin
              if (rx_count_q >= CW'(RX_BUFFER_BYTES)) begin
                post_st_q <= ST_SIZE;
                phase_q   <= PH_IDLE;
                state_q   <= S_ST;
              end else begin
                // crc runs two bytes behind the newest byte
                if (rx_count_q >= CW'(2)) begin
                  crc_rx_q <= crc16_byte(crc_rx_q, byte_old_q);
                end
                byte_old_q <= byte_new_q;
                byte_new_q <= in_s.rx_byte;
                rx_count_q <= rx_count_q + CW'(1);
                state_q    <= S_CHK;
              end
            end else if (in_s.operation == OP_TICK && phase_q != PH_IDLE) begin
              tick_q <= tick_inc;
              if (tick_inc >= lim) begin
                post_st_q <= ST_TIMEOUT;
                phase_q   <= PH_IDLE;
                state_q   <= S_ST;
              end
            end
          end
        end

        S_CHK: begin
          if (phase_q == PH_ACK && rx_count_q >= CW'(7)) begin
            if (crc_ok) begin
              // acknowledgement good: send poll frame
              frame_q[0] <= station_q;
              frame_q[1] <= HOST_ID;
              frame_q[2] <= 8'd0;
              frame_q[3] <= 8'd1;
              frame_q[4] <= 8'd0;
              flen_q     <= 4'd5;
              fidx_q     <= '0;
              crc_tx_q   <= CRC_INIT;
              need_q     <= (cmd_q == CMD_READ) ? need_calc : 10'd7;
              rx_count_q <= '0;
              tick_q     <= '0;
              crc_rx_q   <= CRC_INIT;
              if (cmd_q == CMD_READ && need_calc > 10'(RX_BUFFER_BYTES)) begin
                post_st_q <= ST_SIZE;
                phase_q   <= PH_IDLE;
              end else begin
                post_st_q <= ST_BUSY;
                phase_q   <= PH_RESP;
              end
              state_q <= S_TX;
            end else begin
              post_st_q <= ST_CRC;
              phase_q   <= PH_IDLE;
              state_q   <= S_ST;
            end
          end else if (phase_q == PH_RESP && 10'(rx_count_q) >= need_q) begin
            phase_q <= PH_IDLE;
            if (!crc_ok) begin
              post_st_q <= ST_CRC;
              state_q   <= S_ST;
            end else if (cmd_q != CMD_READ) begin
              post_st_q <= ST_OK;
              state_q   <= S_ST;
            end else if (analog_q) begin
              state_q <= S_AREQ;
            end else if (count_q == 8'd0) begin
              post_st_q <= ST_OK;
              state_q   <= S_ST;
            end else begin
              waddr_q <= AW'(4);
              widx_q  <= target_q;
              wleft_q <= count_q;
              state_q <= S_WREQ;
            end
          end else begin
            state_q <= S_IDLE;
          end
        end

        S_TX: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= KIND_TX;
            out_tx_q    <= tx_cur;
            out_idx_q   <= '0;
            out_val_q   <= '0;
            out_st_q    <= ST_BUSY;
            out_last_q  <= (fidx_q == flen_q + 4'd1) && (post_st_q == ST_BUSY);
            if (fidx_q < flen_q) begin
              crc_tx_q <= crc16_byte(crc_tx_q, tx_cur);
            end
            fidx_q <= fidx_q + 4'd1;
            if (fidx_q == flen_q + 4'd1) begin
              state_q <= (post_st_q != ST_BUSY) ? S_ST : S_IDLE;
            end
          end
        end

        S_ST: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= KIND_STATUS;
            out_tx_q    <= '0;
            out_idx_q   <= '0;
            out_val_q   <= '0;
            out_st_q    <= post_st_q;
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        // analog read: channel byte first
        S_AREQ: begin
          state_q <= S_ACH;
        end

        S_ACH: begin
          widx_q  <= target_q + 16'd3 - {14'd0, rdata_a[1:0]};
          waddr_q <= AW'(4);
          wleft_q <= 8'd1;
          state_q <= S_WREQ;
        end

        S_WREQ: begin
          state_q <= S_WOUT;
        end

        S_WOUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_kind_q  <= KIND_WORD;
            out_tx_q    <= '0;
            out_idx_q   <= widx_q;
            out_val_q   <= {rdata_b, rdata_a};
            out_st_q    <= (wleft_q == 8'd1) ? ST_OK : ST_BUSY;
            out_last_q  <= (wleft_q == 8'd1);
            wleft_q     <= wleft_q - 8'd1;
            widx_q      <= widx_q + 16'd1;
            waddr_q     <= waddr_q + AW'(2);
            state_q     <= (wleft_q == 8'd1) ? S_IDLE : S_WREQ;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
